// ===== rtl/core/pattern_match_line_column_macros.svh =====
// Assertion macros shared by the matcher RTL.
`ifndef PATTERN_MATCH_LINE_COLUMN_MACROS_SVH
`define PATTERN_MATCH_LINE_COLUMN_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, quiet while reset is high.
`define PMLC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pmlc assertion failed");
// Checked property, also evaluated through reset.
`define PMLC_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pmlc reset assertion failed");
`else
`define PMLC_ASSERT(label, clk, rst, prop)
`define PMLC_ASSERT_RST(label, clk, prop)
`endif

`endif

// ===== rtl/core/pmlc_pkg.sv =====
`default_nettype none
package pmlc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PATTERN_DEF = 32;
  localparam int CHAR_BITS_DEF   = 8;

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 5;
  localparam int CHARV_W = 8;
  localparam int LEN_W   = 6;
  localparam int INDEX_W = 32;
  localparam int LINE_W  = 20;
  localparam int COL_W   = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  localparam logic [CHARV_W-1:0] NEWLINE_CODE = 8'd10;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  pattern_slot;
    logic [CHARV_W-1:0] char_value;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] match_index;
    logic [LINE_W-1:0]  match_line;
    logic [COL_W-1:0]   match_column;
  } out_t;

  // Text position carried along the window
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } pos_t;

endpackage
`default_nettype wire

// ===== rtl/core/pmlc_cell.sv =====
`default_nettype none
module pmlc_cell #(
  parameter int CW = 8,
  parameter int IW = 5,
  parameter int J  = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            clear,
  input  logic [CW-1:0]   ch_in,
  input  pmlc_pkg::pos_t  pos_in,
  input  logic            valid_in,
  input  logic            act,
  input  logic            pw_en,
  input  logic [IW-1:0]   pw_addr,
  input  logic [CW-1:0]   pw_data,
  output logic [CW-1:0]   ch_out,
  output pmlc_pkg::pos_t  pos_out,
  output logic            valid_out,
  output logic            eq
);
  import pmlc_pkg::*;

  logic [CW-1:0] ch;
  pos_t          pos;
  logic          valid;
  logic [CW-1:0] pat;

  // Occupancy: cleared by reset and by a start word
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_in;
    end
  end

  // Window slot and aligned pattern character
  always_ff @(posedge clk) begin
    if (shift) begin
      ch  <= ch_in;
      pos <= pos_in;
    end
    if (pw_en && (pw_addr == IW'(J))) begin
      pat <= pw_data;
    end
  end

  // Slots beyond the pattern length always agree
  assign eq        = !act || (valid && (ch == pat));
  assign ch_out    = ch;
  assign pos_out   = pos;
  assign valid_out = valid;

endmodule
`default_nettype wire

// ===== rtl/core/pmlc_pattern.sv =====
`default_nettype none
module pmlc_pattern #(
  parameter int MAXP = 32,
  parameter int CW   = 8,
  parameter int IW   = 5,
  parameter int PW   = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [pmlc_pkg::SLOT_W-1:0] slot,
  input  logic [CW-1:0]             data,
  input  logic [PW-1:0]             plen,
  input  logic                      sweep_start,
  output logic                      busy,
  output logic                      pw_en,
  output logic [IW-1:0]             pw_addr,
  output logic [CW-1:0]             pw_data
);
  import pmlc_pkg::*;

  localparam int DW = (PW > SLOT_W) ? PW : SLOT_W;

  logic [CW-1:0] store [MAXP];
  logic          sweeping;
  logic [IW-1:0] cnt;
  logic          s_v;
  logic          s_en;
  logic [IW-1:0] s_addr;
  logic [CW-1:0] rd_data;

  logic          slot_ok;
  logic          dir_en;
  logic [DW-1:0] dir_addr;
  logic [DW-1:0] rd_addr;
  logic          cnt_in_len;

  assign slot_ok    = 32'(slot) < MAXP;
  assign dir_en     = load && slot_ok && (DW'(slot) < DW'(plen));
  assign dir_addr   = DW'(plen) - DW'(1) - DW'(slot);
  assign cnt_in_len = DW'(cnt) < DW'(plen);
  assign rd_addr    = DW'(plen) - DW'(1) - DW'(cnt);

  // Pattern store, one write and one registered read
  always_ff @(posedge clk) begin
    if (load && slot_ok) begin
      store[IW'(slot)] <= data;
    end
    rd_data <= store[IW'(rd_addr)];
    s_addr  <= cnt;
  end

  // Realignment sweep after a length change
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping <= 1'b0;
      cnt      <= '0;
      s_v      <= 1'b0;
      s_en     <= 1'b0;
    end else begin
      s_v  <= sweeping;
      s_en <= sweeping && cnt_in_len;
      if (sweep_start) begin
        sweeping <= 1'b1;
        cnt      <= '0;
      end else if (sweeping) begin
        if (cnt == IW'(MAXP - 1)) begin
          sweeping <= 1'b0;
        end
        cnt <= cnt + IW'(1);
      end
    end
  end

  assign busy    = sweeping || s_v;
  assign pw_en   = s_en || dir_en;
  assign pw_addr = s_en ? s_addr : IW'(dir_addr);
  assign pw_data = s_en ? rd_data : data;

endmodule
`default_nettype wire

// ===== rtl/core/pattern_match_line_column.sv =====
// Timing: a text word shifts into cell 0 and sets pend at its accepting edge; the compare
// across the cells is combinational, and a hit is registered into out_* once the output is free.
// Throughput: one input word per cycle from the combinational compare, unless in_ready is low.
// A configuration write starts a realignment sweep over all pattern slots with in_ready low.
// Reset (rst, synchronous): clears the window, counters, pattern length and out_valid.
`default_nettype none
`include "pattern_match_line_column_macros.svh"
module pattern_match_line_column #(
  parameter int MAX_PATTERN = pmlc_pkg::MAX_PATTERN_DEF,
  parameter int CHAR_BITS   = pmlc_pkg::CHAR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pmlc_pkg::in_t              in_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pmlc_pkg::out_t             out_word,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pmlc_pkg::LEN_W-1:0] cfg_data
);
  import pmlc_pkg::*;

  localparam int CW = CHAR_BITS;
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PW = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]   plen_reg;
  logic [PW-1:0]      plen_eff;
  logic [INDEX_W-1:0] char_idx;
  logic [INDEX_W-1:0] eval_idx;
  logic [LINE_W-1:0]  line_cnt;
  logic [COL_W-1:0]   col_cnt;
  logic               pend;

  logic               in_acc;
  logic               text_acc;
  logic               load_acc;
  logic               start_acc;
  logic               cfg_acc;
  logic               out_free;
  logic               hit;
  logic               hit_go;
  logic               pat_busy;
  logic [CW-1:0]      ch_new;
  pos_t               pos_new;

  logic               pw_en;
  logic [IW-1:0]      pw_addr;
  logic [CW-1:0]      pw_data;

  logic [CW-1:0]          ch_q    [MAX_PATTERN];
  pos_t                   pos_q   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] valid_q;
  logic [MAX_PATTERN-1:0] eq;
  logic [MAX_PATTERN-1:0] act;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && in_ready;
  assign text_acc  = in_acc && (in_word.cmd == CMD_TEXT);
  assign load_acc  = in_acc && (in_word.cmd == CMD_LOAD);
  assign start_acc = in_acc && (in_word.cmd == CMD_START);
  assign out_free  = !out_valid || out_ready;
  assign hit_go    = pend && hit;
  assign in_ready  = !pat_busy && (!hit_go || out_free);

  // Pattern length, capped at the window depth
  always_ff @(posedge clk) begin
    if (rst) begin
      plen_reg <= '0;
    end else if (cfg_acc) begin
      plen_reg <= cfg_data;
    end
  end

  assign plen_eff = (32'(plen_reg) > MAX_PATTERN) ? PW'(MAX_PATTERN) : PW'(plen_reg);

  // Position counters, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      char_idx <= '0;
      line_cnt <= '0;
      col_cnt  <= '0;
    end else if (start_acc) begin
      char_idx <= '0;
      line_cnt <= '0;
      col_cnt  <= '0;
    end else if (text_acc) begin
      if (char_idx != '1) begin
        char_idx <= char_idx + INDEX_W'(1);
      end
      if (ch_new == CW'(NEWLINE_CODE)) begin
        col_cnt <= '0;
        if (line_cnt != '1) begin
          line_cnt <= line_cnt + LINE_W'(1);
        end
      end else if (col_cnt != '1) begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  assign ch_new       = CW'(in_word.char_value);
  assign pos_new.line = line_cnt;
  assign pos_new.col  = col_cnt;

  // Pattern store and alignment into the cells
  pmlc_pattern #(
    .MAXP (MAX_PATTERN),
    .CW   (CW),
    .IW   (IW),
    .PW   (PW)
  ) u_pattern (
    .clk         (clk),
    .rst         (rst),
    .load        (load_acc),
    .slot        (in_word.pattern_slot),
    .data        (ch_new),
    .plen        (plen_eff),
    .sweep_start (cfg_acc),
    .busy        (pat_busy),
    .pw_en       (pw_en),
    .pw_addr     (pw_addr),
    .pw_data     (pw_data)
  );

  // Window chain, newest character in cell 0
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    assign act[j] = 32'(plen_eff) > j;
    if (j == 0) begin : g_head
      pmlc_cell #(.CW(CW), .IW(IW), .J(j)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (text_acc),
        .clear     (start_acc),
        .ch_in     (ch_new),
        .pos_in    (pos_new),
        .valid_in  (1'b1),
        .act       (act[j]),
        .pw_en     (pw_en),
        .pw_addr   (pw_addr),
        .pw_data   (pw_data),
        .ch_out    (ch_q[j]),
        .pos_out   (pos_q[j]),
        .valid_out (valid_q[j]),
        .eq        (eq[j])
      );
    end else begin : g_body
      pmlc_cell #(.CW(CW), .IW(IW), .J(j)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (text_acc),
        .clear     (start_acc),
        .ch_in     (ch_q[j-1]),
        .pos_in    (pos_q[j-1]),
        .valid_in  (valid_q[j-1]),
        .act       (act[j]),
        .pw_en     (pw_en),
        .pw_addr   (pw_addr),
        .pw_data   (pw_data),
        .ch_out    (ch_q[j]),
        .pos_out   (pos_q[j]),
        .valid_out (valid_q[j]),
        .eq        (eq[j])
      );
    end
  end

  assign hit = (plen_eff != '0) && (&eq);

  // Evaluation pending for the word last shifted in
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (!(hit_go && !out_free)) begin
      pend <= text_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) begin
      eval_idx <= char_idx;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hit_go;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && hit_go) begin
      out_word.match_index  <= eval_idx - (INDEX_W'(plen_eff) - INDEX_W'(1));
      out_word.match_line   <= pos_q[IW'(plen_eff - PW'(1))].line;
      out_word.match_column <= pos_q[IW'(plen_eff - PW'(1))].col;
    end
  end

  // Checks
  `PMLC_ASSERT(a_sweep_blocks_input, clk, rst, pat_busy |-> !in_ready)
  `PMLC_ASSERT(a_stall_holds_eval, clk, rst, (hit_go && !out_free) |=> pend)
  `PMLC_ASSERT(a_hit_loads_output, clk, rst, (hit_go && out_free) |=> out_valid)
  `PMLC_ASSERT(a_window_fills_in_order, clk, rst, (valid_q & (valid_q + 1'b1)) == '0)
  `PMLC_ASSERT_RST(a_reset_idle, clk, rst |=> (!out_valid && !pend))

endmodule
`default_nettype wire
